// ===== rtl/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants of the station actuation sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

	// Sequencer modes, as reported in cycle_state
	localparam logic [2:0] MODE_STOPPED    = 3'd0;
	localparam logic [2:0] MODE_ESTOPPED   = 3'd1;
	localparam logic [2:0] MODE_READY      = 3'd2;
	localparam logic [2:0] MODE_START_MOVE = 3'd3;
	localparam logic [2:0] MODE_HOME_MOVE  = 3'd4;
	localparam logic [2:0] MODE_REPORT     = 3'd5;
	localparam logic [2:0] MODE_WAIT       = 3'd6;

	// Request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// Servo commands
	localparam logic [1:0] SERVO_NONE = 2'd0;
	localparam logic [1:0] SERVO_ONE  = 2'd1;
	localparam logic [1:0] SERVO_ALL  = 2'd2;

	// Register indexes
	localparam logic [2:0] CFG_ENABLE_MASK = 3'd0;
	localparam logic [2:0] CFG_START_MOVE  = 3'd1;
	localparam logic [2:0] CFG_HOME_MOVE   = 3'd2;
	localparam logic [2:0] CFG_CPM         = 3'd3;
	localparam logic [2:0] CFG_START_ANGLE = 3'd4;
	localparam logic [2:0] CFG_HOME_ANGLE  = 3'd5;

	localparam int unsigned MASK_BITS     = 4;
	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
	localparam int unsigned DIV_STEPS     = 16;
	localparam int unsigned DIVISOR_W     = 18;

	// Configuration registers
	typedef struct packed {
		logic [3:0]  enable_mask;
		logic [15:0] start_move_ms;
		logic [15:0] home_move_ms;
		logic [15:0] cycles_per_minute;
		logic [8:0]  start_angle;
		logic [8:0]  home_angle;
	} sas_cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_step;
		logic commit;
	} sas_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_last;
		logic out_busy;
	} sas_sts_t;

	// One result word
	typedef struct packed {
		logic [15:0] report_peak;
		logic [1:0]  report_station;
		logic        report_valid;
		logic [8:0]  servo_angle;
		logic [1:0]  servo_station;
		logic [1:0]  servo_cmd;
		logic        accepted;
		logic [2:0]  cycle_state;
	} sas_res_t;

endpackage

// ===== rtl/sas_cfg.sv =====
// ----------------------------------------------------------------------------
// sas_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sas_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output sas_pkg::sas_cfg_t cfg
);

	sas_pkg::sas_cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_mask       <= 4'd15;
			cfg_q.start_move_ms     <= 16'd500;
			cfg_q.home_move_ms      <= 16'd1000;
			cfg_q.cycles_per_minute <= 16'd30;
			cfg_q.start_angle       <= 9'd90;
			cfg_q.home_angle        <= 9'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sas_pkg::CFG_ENABLE_MASK: cfg_q.enable_mask       <= cfg_data[3:0];
				sas_pkg::CFG_START_MOVE:  cfg_q.start_move_ms     <= cfg_data;
				sas_pkg::CFG_HOME_MOVE:   cfg_q.home_move_ms      <= cfg_data;
				sas_pkg::CFG_CPM:         cfg_q.cycles_per_minute <= cfg_data;
				sas_pkg::CFG_START_ANGLE: cfg_q.start_angle       <= cfg_data[8:0];
				sas_pkg::CFG_HOME_ANGLE:  cfg_q.home_angle        <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sas_ctrl.sv =====
// ----------------------------------------------------------------------------
// sas_ctrl
// Control FSM: takes a word, runs the wait-period divider, commits the step.
// ----------------------------------------------------------------------------
module sas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sas_pkg::sas_sts_t sts,
	output sas_pkg::sas_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_EXEC = 4'b1000
	} state_t;

	state_t state_q, state_n;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_n = S_LOAD;
			S_LOAD: state_n = S_DIV;
			S_DIV:  if (sts.div_last) state_n = S_EXEC;
			S_EXEC: if (!sts.out_busy) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Commands
	assign in_ready      = (state_q == S_IDLE);
	assign cmd.capture   = in_ready && in_valid;
	assign cmd.div_start = (state_q == S_LOAD);
	assign cmd.div_step  = (state_q == S_DIV);
	assign cmd.commit    = (state_q == S_EXEC) && !sts.out_busy;

`ifndef SYNTH
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !in_ready)
		else $error("second word taken while one is in work");
	a_div_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.div_last) |=> (state_q == S_EXEC))
		else $error("divider finished without commit stage");
`endif

endmodule

// ===== rtl/sas_dp.sv =====
// ----------------------------------------------------------------------------
// sas_dp
// Datapath: input capture, wait-period divider, sequencer state, result word.
// ----------------------------------------------------------------------------
module sas_dp #(
	parameter int NUM_STATIONS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sas_pkg::sas_cfg_t cfg,
	input  sas_pkg::sas_cmd_t cmd,
	output sas_pkg::sas_sts_t sts,
	input  logic [1:0]        in_req,
	input  logic [31:0]       in_now,
	input  logic              in_estop,
	input  logic [15:0]       in_sample,
	output logic              out_valid,
	input  logic              out_ready,
	output sas_pkg::sas_res_t out_res
);

	localparam int IW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
	localparam int DW = sas_pkg::DIVISOR_W;

	// Captured word
	logic [1:0]  req_q;
	logic [31:0] now_q;
	logic        estop_q;
	logic [15:0] sample_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= in_req;
			now_q    <= in_now;
			estop_q  <= in_estop;
			sample_q <= in_sample;
		end
	end

	// Enabled station count
	logic [2:0] en_count;
	always_comb begin
		en_count = '0;
		for (int i = 0; i < sas_pkg::MASK_BITS; i++) begin
			if (i < NUM_STATIONS && cfg.enable_mask[i]) en_count = en_count + 3'd1;
		end
	end

	// Restoring divider: 60000 / (cpm * count), one quotient bit per cycle
	logic [DW-1:0] divisor_q;
	logic [DW-1:0] rem_q;
	logic [15:0]   quo_q;
	logic [3:0]    div_cnt_q;
	logic [18:0]   product;
	logic [DW+1:0] diff;
	logic [15:0]   period;

	assign product = cfg.cycles_per_minute * en_count;
	assign diff    = {1'b0, rem_q, quo_q[15]} - {2'b00, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			divisor_q <= product[DW-1:0];
			rem_q     <= '0;
			quo_q     <= sas_pkg::MS_PER_MINUTE;
		end else if (cmd.div_step) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign sts.div_last = (div_cnt_q == 4'(sas_pkg::DIV_STEPS - 1));
	assign period       = (divisor_q == '0) ? 16'd0 : quo_q;

	// Sequencer state
	logic [2:0]    mode_q;
	logic [IW-1:0] station_q;
	logic [31:0]   start_time_q;
	logic [15:0]   peak_q;

	logic [2:0]    mode_n, mode_t;
	logic [IW-1:0] station_n, station_inc;
	logic [31:0]   start_time_n;
	logic [15:0]   peak_n, peak_max;
	logic [31:0]   elapsed;
	logic          station_on;
	logic          stopped;
	sas_pkg::sas_res_t res;

	assign elapsed     = now_q - start_time_q;
	assign station_on  = (32'(station_q) < sas_pkg::MASK_BITS)
		&& cfg.enable_mask[2'(station_q)];
	assign station_inc = (station_q == IW'(NUM_STATIONS - 1)) ? '0 : station_q + 1'b1;
	assign peak_max    = (sample_q > peak_q) ? sample_q : peak_q;
	assign stopped     = (mode_q == sas_pkg::MODE_STOPPED)
		|| (mode_q == sas_pkg::MODE_ESTOPPED);

	// One step of the sequencer
	always_comb begin
		mode_n       = mode_q;
		mode_t       = mode_q;
		station_n    = station_q;
		start_time_n = start_time_q;
		peak_n       = peak_q;
		res          = '0;
		unique case (req_q)
			sas_pkg::REQ_START: begin
				if (stopped && !estop_q) begin
					mode_n       = sas_pkg::MODE_READY;
					res.accepted = 1'b1;
				end
			end
			sas_pkg::REQ_STOP: begin
				if (!stopped) begin
					mode_n       = sas_pkg::MODE_STOPPED;
					res.accepted = 1'b1;
				end
			end
			sas_pkg::REQ_TICK: begin
				// e-stop check comes first
				if (estop_q && mode_q != sas_pkg::MODE_ESTOPPED) begin
					res.servo_cmd   = sas_pkg::SERVO_ALL;
					res.servo_angle = cfg.home_angle;
					mode_t          = sas_pkg::MODE_ESTOPPED;
				end else if (!estop_q && mode_q == sas_pkg::MODE_ESTOPPED) begin
					mode_t = sas_pkg::MODE_STOPPED;
				end
				mode_n = mode_t;
				unique case (mode_t)
					sas_pkg::MODE_READY: begin
						if (station_on) begin
							start_time_n = now_q;
							peak_n       = '0;
							mode_n       = sas_pkg::MODE_START_MOVE;
						end else begin
							station_n = station_inc;
						end
					end
					sas_pkg::MODE_START_MOVE: begin
						peak_n            = peak_max;
						res.servo_cmd     = sas_pkg::SERVO_ONE;
						res.servo_station = 2'(station_q);
						res.servo_angle   = cfg.start_angle;
						if (elapsed > {16'd0, cfg.start_move_ms})
							mode_n = sas_pkg::MODE_HOME_MOVE;
					end
					sas_pkg::MODE_HOME_MOVE: begin
						peak_n            = peak_max;
						res.servo_cmd     = sas_pkg::SERVO_ONE;
						res.servo_station = 2'(station_q);
						res.servo_angle   = cfg.home_angle;
						if (elapsed > {16'd0, cfg.home_move_ms})
							mode_n = sas_pkg::MODE_REPORT;
					end
					sas_pkg::MODE_REPORT: begin
						res.report_valid   = 1'b1;
						res.report_station = 2'(station_q);
						res.report_peak    = peak_q;
						station_n          = station_inc;
						mode_n             = sas_pkg::MODE_WAIT;
					end
					sas_pkg::MODE_WAIT: begin
						if (elapsed > {16'd0, period}) mode_n = sas_pkg::MODE_READY;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		res.cycle_state = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= sas_pkg::MODE_STOPPED;
			station_q    <= '0;
			start_time_q <= '0;
			peak_q       <= '0;
		end else if (cmd.commit) begin
			mode_q       <= mode_n;
			station_q    <= station_n;
			start_time_q <= start_time_n;
			peak_q       <= peak_n;
		end
	end

	// Output register
	logic     out_valid_q;
	sas_pkg::sas_res_t out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) out_res_q <= res;
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_res      = out_res_q;

`ifndef SYNTH
	a_estop_home: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res.servo_cmd == sas_pkg::SERVO_ALL)
		|-> (res.cycle_state == sas_pkg::MODE_ESTOPPED))
		else $error("all-home command without e-stop mode");
	a_report_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && res.report_valid) |-> (res.cycle_state == sas_pkg::MODE_WAIT))
		else $error("report not followed by wait");
	a_div_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (div_cnt_q == '0))
		else $error("divider step count not cleared");
`endif

endmodule

// ===== rtl/station_actuation_sequencer.sv =====
// A taken word passes through a load state, the 16-step wait-period divider and a commit
// state that loads the output register; its result word then shows on m_tvalid.
// No new word is taken until the previous one has been committed.
// s_tready is high only while idle; a taken word waits at commit while a result is not taken.
// Reset (arst_n low, asynchronous): mode stopped, station 0, timers and peak 0,
// registers to their defaults, no result pending.
// ----------------------------------------------------------------------------
// station_actuation_sequencer
// Round-robin test station sequencer with e-stop handling and peak tracking.
// ----------------------------------------------------------------------------
module station_actuation_sequencer #(
	parameter int NUM_STATIONS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // now_ms[31:0], estop_active[32], current_sample[48:33]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // cycle_state[2:0], accepted[3], servo_cmd[5:4],
	                              // servo_station[7:6], servo_angle[16:8], report_valid[17],
	                              // report_station[19:18], report_peak[35:20]
);

	sas_pkg::sas_cfg_t cfg;
	sas_pkg::sas_cmd_t cmd;
	sas_pkg::sas_sts_t sts;
	sas_pkg::sas_res_t res;

	sas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sas_dp #(
		.NUM_STATIONS (NUM_STATIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.in_req    (s_tuser),
		.in_now    (s_tdata[31:0]),
		.in_estop  (s_tdata[32]),
		.in_sample (s_tdata[48:33]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Result word packing, zero fill to whole bytes
	assign m_tdata = {4'd0, res};

endmodule

// ===== bench/tb_station_actuation_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_station_actuation_sequencer
// Self-checking bench: directed e-stop, start/stop and wrap-around cases, then
// random request streams under several register settings and handshake loads.
// Every word the block returns is checked against an in-bench sequencer model.
// ----------------------------------------------------------------------------
module tb_station_actuation_sequencer;

	localparam int NUM_STATIONS = 4;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;

	// Sequencer model plus the queue of result words it predicts
	class sas_scoreboard;
		logic [3:0]  enable_mask;
		logic [15:0] start_move_ms;
		logic [15:0] home_move_ms;
		logic [15:0] cycles_per_minute;
		logic [8:0]  start_angle;
		logic [8:0]  home_angle;
		logic [2:0]  mode;
		logic [1:0]  station;
		logic [31:0] cycle_start;
		logic [15:0] peak;
		sas_pkg::sas_res_t step_results_q[$];
		int          mismatch_count;
		int          words_checked;

		function new();
			enable_mask       = 4'd15;
			start_move_ms     = 16'd500;
			home_move_ms      = 16'd1000;
			cycles_per_minute = 16'd30;
			start_angle       = 9'd90;
			home_angle        = 9'd0;
			mode              = sas_pkg::MODE_STOPPED;
			station           = 2'd0;
			cycle_start       = 32'd0;
			peak              = 16'd0;
			mismatch_count    = 0;
			words_checked     = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				sas_pkg::CFG_ENABLE_MASK: enable_mask       = val[3:0];
				sas_pkg::CFG_START_MOVE:  start_move_ms     = val;
				sas_pkg::CFG_HOME_MOVE:   home_move_ms      = val;
				sas_pkg::CFG_CPM:         cycles_per_minute = val;
				sas_pkg::CFG_START_ANGLE: start_angle       = val[8:0];
				sas_pkg::CFG_HOME_ANGLE:  home_angle        = val[8:0];
				default: ;
			endcase
		endfunction

		function int unsigned enabled_count();
			int unsigned n;
			n = 0;
			for (int i = 0; i < NUM_STATIONS && i < int'(sas_pkg::MASK_BITS); i++)
				if (enable_mask[i])
					n++;
			return n;
		endfunction

		function int unsigned wait_period_ms();
			int unsigned divisor;
			divisor = 32'(cycles_per_minute) * enabled_count();
			return (divisor == 0) ? 0 : 32'(sas_pkg::MS_PER_MINUTE) / divisor;
		endfunction

		function logic [1:0] next_station(logic [1:0] idx);
			return 2'((int'(idx) + 1) % NUM_STATIONS);
		endfunction

		// One request through the sequencer; returns the word it produces
		function sas_pkg::sas_res_t advance_sequencer(logic [1:0] req, logic [31:0] now_ms,
				logic estop, logic [15:0] sample);
			sas_pkg::sas_res_t r;
			logic [31:0] elapsed;
			r = '0;
			case (req)
				sas_pkg::REQ_START: begin
					if ((mode == sas_pkg::MODE_STOPPED || mode == sas_pkg::MODE_ESTOPPED)
							&& !estop) begin
						mode = sas_pkg::MODE_READY;
						r.accepted = 1'b1;
					end
				end
				sas_pkg::REQ_STOP: begin
					if (mode != sas_pkg::MODE_STOPPED && mode != sas_pkg::MODE_ESTOPPED) begin
						mode = sas_pkg::MODE_STOPPED;
						r.accepted = 1'b1;
					end
				end
				sas_pkg::REQ_TICK: begin
					// e-stop takes priority over the station sequence
					if (estop && mode != sas_pkg::MODE_ESTOPPED) begin
						r.servo_cmd   = sas_pkg::SERVO_ALL;
						r.servo_angle = home_angle;
						mode          = sas_pkg::MODE_ESTOPPED;
					end else if (!estop && mode == sas_pkg::MODE_ESTOPPED) begin
						mode = sas_pkg::MODE_STOPPED;
					end
					elapsed = now_ms - cycle_start;
					case (mode)
						sas_pkg::MODE_READY: begin
							if (enable_mask[station]) begin
								cycle_start = now_ms;
								peak        = 16'd0;
								mode        = sas_pkg::MODE_START_MOVE;
							end else begin
								station = next_station(station);
							end
						end
						sas_pkg::MODE_START_MOVE: begin
							if (sample > peak)
								peak = sample;
							r.servo_cmd     = sas_pkg::SERVO_ONE;
							r.servo_station = station;
							r.servo_angle   = start_angle;
							if (elapsed > 32'(start_move_ms))
								mode = sas_pkg::MODE_HOME_MOVE;
						end
						sas_pkg::MODE_HOME_MOVE: begin
							if (sample > peak)
								peak = sample;
							r.servo_cmd     = sas_pkg::SERVO_ONE;
							r.servo_station = station;
							r.servo_angle   = home_angle;
							if (elapsed > 32'(home_move_ms))
								mode = sas_pkg::MODE_REPORT;
						end
						sas_pkg::MODE_REPORT: begin
							r.report_valid   = 1'b1;
							r.report_station = station;
							r.report_peak    = peak;
							station          = next_station(station);
							mode             = sas_pkg::MODE_WAIT;
						end
						sas_pkg::MODE_WAIT: begin
							if (elapsed > wait_period_ms())
								mode = sas_pkg::MODE_READY;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			r.cycle_state = mode;
			return r;
		endfunction

		function void note_word(logic [1:0] req, logic [31:0] now_ms, logic estop,
				logic [15:0] sample);
			step_results_q.push_back(advance_sequencer(req, now_ms, estop, sample));
		endfunction

		function int outstanding();
			return step_results_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH word %0d: %s", words_checked, msg);
			mismatch_count++;
		endtask

		task check_word(logic [39:0] word);
			sas_pkg::sas_res_t got;
			sas_pkg::sas_res_t want;
			int unsigned g[8];
			int unsigned w[8];
			string       field_names[8];
			got = word[35:0];
			words_checked++;
			if (step_results_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result word %h", word));
				return;
			end
			want = step_results_q.pop_front();
			field_names = '{"cycle_state", "accepted", "servo_cmd", "servo_station",
				"servo_angle", "report_valid", "report_station", "report_peak"};
			g = '{got.cycle_state, got.accepted, got.servo_cmd, got.servo_station,
				got.servo_angle, got.report_valid, got.report_station, got.report_peak};
			w = '{want.cycle_state, want.accepted, want.servo_cmd, want.servo_station,
				want.servo_angle, want.report_valid, want.report_station, want.report_peak};
			for (int i = 0; i < 8; i++)
				if (g[i] != w[i])
					report_mismatch($sformatf("%s got %0d, expected %0d",
						field_names[i], g[i], w[i]));
		endtask

		task check_leftover();
			if (step_results_q.size() != 0)
				report_mismatch($sformatf("%0d result words never came",
					step_results_q.size()));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // now_ms[31:0], estop_active[32], current_sample[48:33]
	logic [1:0]  s_tuser;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // cycle_state, accepted, servo_cmd, servo_station, servo_angle,
	                        // report_valid, report_station, report_peak

	sas_scoreboard sb;
	logic [31:0]   now_ms;
	int            sender_idle_pct;
	int            receiver_stall_pct;
	int            cycle_count = 0;

	station_actuation_sequencer #(
		.NUM_STATIONS(NUM_STATIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: random back-pressure, check every taken word
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	// Present one request word; returns at the falling edge after it is taken
	task automatic send_word(input logic [1:0] req, input logic [31:0] t_ms,
			input logic estop, input logic [15:0] sample);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = req;
		s_tdata  = {7'd0, sample, estop, t_ms};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_word(req, t_ms, estop, sample);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		s_tvalid = 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic load_settings(input logic [15:0] mask, input logic [15:0] smove,
			input logic [15:0] hmove, input logic [15:0] cpm, input logic [15:0] sang,
			input logic [15:0] hang);
		wait_results_drained();
		write_reg(sas_pkg::CFG_ENABLE_MASK, mask);
		write_reg(sas_pkg::CFG_START_MOVE, smove);
		write_reg(sas_pkg::CFG_HOME_MOVE, hmove);
		write_reg(sas_pkg::CFG_CPM, cpm);
		write_reg(sas_pkg::CFG_START_ANGLE, sang);
		write_reg(sas_pkg::CFG_HOME_ANGLE, hang);
	endtask

	// Mostly ticks with time steps scaled to the current move and wait spans
	task automatic send_random_word();
		int          pick;
		int unsigned stride;
		logic [1:0]  req;
		logic        estop;
		logic        halted;
		halted = (sb.mode == sas_pkg::MODE_STOPPED || sb.mode == sas_pkg::MODE_ESTOPPED);
		stride = (32'(sb.start_move_ms) + 32'(sb.home_move_ms) + sb.wait_period_ms()) / 6 + 2;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			req = sas_pkg::REQ_STOP;
		else if (pick < 5)
			req = REQ_UNUSED;
		else if (pick < 8 || (halted && pick < 50))
			req = sas_pkg::REQ_START;
		else
			req = sas_pkg::REQ_TICK;
		estop = ($urandom_range(0, 99) < ((req == sas_pkg::REQ_START) ? 15 : 3));
		pick = $urandom_range(0, 99);
		if (pick < 4)
			now_ms = $urandom;
		else if (pick < 20)
			now_ms = now_ms + $urandom_range(0, 2);
		else
			now_ms = now_ms + $urandom_range(0, stride);
		if ($urandom_range(0, 199) == 0)
			wait_results_drained();
		send_word(req, now_ms, estop, 16'($urandom_range(0, 65535)));
	endtask

	// Stimulus
	initial begin
		logic [31:0] t0;
		sb                 = new();
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = sas_pkg::CFG_ENABLE_MASK;
		cfg_data           = 16'd0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		s_tuser            = sas_pkg::REQ_TICK;
		now_ms             = 32'd0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle requests, e-stop handling, one full station cycle across
		// the 32-bit time wrap, stop while running and while e-stopped
		t0 = 32'hFFFF_FF00;
		send_word(sas_pkg::REQ_TICK, 32'd0, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_STOP, 32'd0, 1'b0, 16'd0);
		send_word(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_word(sas_pkg::REQ_TICK, 32'd1, 1'b1, 16'd0);
		send_word(sas_pkg::REQ_START, 32'd2, 1'b1, 16'd0);
		send_word(sas_pkg::REQ_TICK, 32'd3, 1'b1, 16'd0);
		send_word(sas_pkg::REQ_START, 32'd4, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_TICK, t0, 1'b0, 16'h1234);
		send_word(sas_pkg::REQ_TICK, t0, 1'b0, 16'hFFFF);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd500, 1'b0, 16'd5);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd501, 1'b0, 16'd7);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd1000, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd1001, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd1002, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd1500, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd1501, 1'b0, 16'd3);
		send_word(sas_pkg::REQ_STOP, t0 + 32'd1502, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_STOP, t0 + 32'd1503, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_START, t0 + 32'd1504, 1'b0, 16'd0);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd1505, 1'b1, 16'd0);
		send_word(sas_pkg::REQ_STOP, t0 + 32'd1506, 1'b1, 16'd0);
		send_word(sas_pkg::REQ_TICK, t0 + 32'd1507, 1'b0, 16'd0);
		now_ms = t0 + 32'd1600;

		// Random phases, each under its own register setting and handshake load
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: load_settings(16'd15, 16'd500, 16'd1000, 16'd30, 16'd90, 16'd0);
				// no station enabled, slowest rate
				1: load_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'd360, 16'd0);
				// zero rate gives a zero wait; angles beyond 360 pass through
				2: load_settings(16'd15, 16'd0, 16'd0, 16'd0, 16'd511, 16'd360);
				3: load_settings(16'b1010, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd360);
				4: load_settings(16'b0001, 16'd3, 16'd7, 16'hFFFF, 16'd45, 16'd511);
				default: load_settings(16'($urandom_range(0, 15)), 16'($urandom_range(0, 3000)),
					16'($urandom_range(0, 3000)), 16'($urandom_range(1, 65535)),
					16'($urandom_range(0, 360)), 16'($urandom_range(0, 360)));
			endcase
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
				default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
			endcase
			repeat (94) send_random_word();
		end

		// Drain and let any stray word show up
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.check_leftover();
		if (sb.mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
